### hdl/swm_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types of the sliding window maximum unit.
// No dependencies; imported by swm_cell and sliding_window_maximum_unit.
package swm_pkg;

	// Width and reset value of the window size register.
	localparam int          WIN_W      = 7;
	localparam logic [6:0]  WIN_RESET  = 7'd4;

	// Default configuration of the top level.
	localparam int          MAX_WINDOW_DEF  = 64;
	localparam int          SAMPLE_BITS_DEF = 16;

	// Control that the top level hands to every cell of the chain.
	typedef struct packed {
		logic accept;   // a sample beat is taken this cycle
		logic first;    // the beat restarts the sequence
		logic pop;      // the front candidate leaves the window on this beat
		logic shift;    // prune cycle: every cell takes its right neighbor
	} step_ctl_t;

endpackage

### hdl/swm_cell.sv
`timescale 1ns / 1ps
// One cell of the candidate chain: holds one candidate (valid, value, age).
// Depends on swm_pkg for the step control struct.
module swm_cell
	import swm_pkg::*;
#(
	parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  step_ctl_t                     ctl,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          nxt_valid,
	input  logic signed [SAMPLE_BITS-1:0] nxt_value,
	input  logic [$clog2(MAX_WINDOW+1)-1:0] nxt_age,
	input  logic                          prv_keep,
	output logic                          keep,
	output logic                          valid,
	output logic signed [SAMPLE_BITS-1:0] value,
	output logic [$clog2(MAX_WINDOW+1)-1:0] age
);

	localparam int AGE_W = $clog2(MAX_WINDOW + 1);

	logic                          valid_q;
	logic signed [SAMPLE_BITS-1:0] value_q;
	logic [AGE_W-1:0]              age_q;
	logic                          src_valid;
	logic signed [SAMPLE_BITS-1:0] src_value;
	logic [AGE_W-1:0]              src_age;
	logic [AGE_W-1:0]              src_age_inc;

	// On a front pop every candidate moves one place toward the front.
	assign src_valid = ctl.pop ? nxt_valid : valid_q;
	assign src_value = ctl.pop ? nxt_value : value_q;
	assign src_age   = ctl.pop ? nxt_age   : age_q;

	assign src_age_inc = (src_age >= AGE_W'(MAX_WINDOW)) ? src_age : src_age + AGE_W'(1);

	// A valid candidate survives unless the beat restarts the sequence or the new sample is strictly larger.
	assign keep = src_valid && !ctl.first && !(src_value < sample);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.accept) begin
			valid_q <= keep || prv_keep;
		end else if (ctl.shift) begin
			valid_q <= nxt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			if (keep) begin
				value_q <= src_value;
				age_q   <= src_age_inc;
			end else begin
				value_q <= sample;
				age_q   <= '0;
			end
		end else if (ctl.shift) begin
			value_q <= nxt_value;
			age_q   <= nxt_age;
		end
	end

	assign valid = valid_q;
	assign value = value_q;
	assign age   = age_q;

endmodule

### hdl/sliding_window_maximum_unit.sv
`timescale 1ns / 1ps
// Top level of the sliding window maximum unit: candidate cell chain,
// window register, fill counter and output register. Depends on swm_pkg, swm_cell.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+--------------------------
//   input    | in_valid / in_ready       | sample, first
//   output   | out_valid / out_ready     | window_max
//   config   | cfg_wr_en (no wait)       | cfg_wr_data (window size)
//
// One sample beat is taken per cycle while in_ready is high; its maximum is in
// the output register in the cycle after. The cell chain updates the whole
// candidate queue on that same edge. After the window is shrunk, in_ready
// stays low while the chain prunes each candidate that is too old beyond the front one.
// Reset empties the queue and the fill counter and sets the window size to 4.
// A held output beat blocks new input only while out_ready stays low.
module sliding_window_maximum_unit
	import swm_pkg::*;
#(
	parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          first,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] window_max,
	input  logic                          cfg_wr_en,
	input  logic [WIN_W-1:0]              cfg_wr_data
);

	localparam int AGE_W = $clog2(MAX_WINDOW + 1);
	localparam int CMP_W = ((AGE_W > WIN_W) ? AGE_W : WIN_W) + 1;

	// The chain holds the monotonic candidate queue, compacted toward cell 0.
	// Values never rise from front to back and ages strictly fall, so expired
	// candidates form a prefix and smaller candidates form a suffix.
	logic                          chain_valid [MAX_WINDOW+1];
	logic signed [SAMPLE_BITS-1:0] chain_value [MAX_WINDOW+1];
	logic [AGE_W-1:0]              chain_age   [MAX_WINDOW+1];
	logic [MAX_WINDOW:0]           chain_keep;
	logic [MAX_WINDOW-1:0]         valid_vec;

	logic [WIN_W-1:0]              window_size_q;
	logic [CMP_W-1:0]              w_eff;
	logic [AGE_W-1:0]              seen_q;
	logic [AGE_W-1:0]              seen_next;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] window_max_q;
	logic                          accept;
	logic                          front_expire;
	logic                          prune;
	logic                          emit;
	logic signed [SAMPLE_BITS-1:0] front_value;
	step_ctl_t                     ctl;

	// Window size register; zero acts as one and the size is capped at the chain length.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= WIN_RESET;
		end else if (cfg_wr_en) begin
			window_size_q <= cfg_wr_data;
		end
	end

	always_comb begin
		if (window_size_q == '0) begin
			w_eff = CMP_W'(1);
		end else if (CMP_W'(window_size_q) > CMP_W'(MAX_WINDOW)) begin
			w_eff = CMP_W'(MAX_WINDOW);
		end else begin
			w_eff = CMP_W'(window_size_q);
		end
	end

	// The front candidate leaves on this beat when its aged value reaches the window.
	assign front_expire = chain_valid[0] && (CMP_W'(chain_age[0]) + CMP_W'(1) >= w_eff);

	// In steady streaming at most the front candidate expires per beat. When the
	// second one would expire too (only after the window was shrunk), the chain
	// drops the front one per cycle and takes no beat until that is settled.
	assign prune = chain_valid[1] && (CMP_W'(chain_age[1]) + CMP_W'(1) >= w_eff);

	assign in_ready = (!out_valid_q || out_ready) && !prune;
	assign accept   = in_valid && in_ready;

	assign ctl.accept = accept;
	assign ctl.first  = first;
	assign ctl.pop    = front_expire;
	assign ctl.shift  = prune;

	assign chain_keep[0]            = 1'b1;
	assign chain_valid[MAX_WINDOW]  = 1'b0;
	assign chain_value[MAX_WINDOW]  = '0;
	assign chain_age[MAX_WINDOW]    = '0;

	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		swm_cell #(
			.MAX_WINDOW  (MAX_WINDOW),
			.SAMPLE_BITS (SAMPLE_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.sample    (sample),
			.nxt_valid (chain_valid[i+1]),
			.nxt_value (chain_value[i+1]),
			.nxt_age   (chain_age[i+1]),
			.prv_keep  (chain_keep[i]),
			.keep      (chain_keep[i+1]),
			.valid     (chain_valid[i]),
			.value     (chain_value[i]),
			.age       (chain_age[i])
		);
		assign valid_vec[i] = chain_valid[i];
	end

	// The new front is the first surviving candidate, or the sample itself when
	// nothing survives. The last keep bit only matters as the chain's tail.
	assign front_value = chain_keep[1] ? (front_expire ? chain_value[1] : chain_value[0])
	                                   : sample;

	// Fill counter, restarting at one on a first beat and saturating at the chain length.
	always_comb begin
		if (first) begin
			seen_next = AGE_W'(1);
		end else if (seen_q >= AGE_W'(MAX_WINDOW)) begin
			seen_next = seen_q;
		end else begin
			seen_next = seen_q + AGE_W'(1);
		end
	end

	assign emit = (CMP_W'(seen_next) >= w_eff) && (chain_keep[MAX_WINDOW] || 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= '0;
			out_valid_q <= 1'b0;
		end else if (accept) begin
			seen_q      <= seen_next;
			out_valid_q <= emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			window_max_q <= front_value;
		end
	end

	assign out_valid  = out_valid_q;
	assign window_max = window_max_q;

	// A beat is never taken while the chain prunes stale candidates.
	a_no_accept_in_prune: assert property (@(posedge clk) disable iff (!arst_n)
		prune |-> !accept)
		else $error("sample beat taken during prune");

	// The queue stays compacted toward the front.
	a_compact: assert property (@(posedge clk) disable iff (!arst_n)
		((valid_vec >> 1) & ~valid_vec) == '0)
		else $error("candidate chain has a hole");

	// Every accepted beat leaves at least its own sample in the queue.
	a_front_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_vec[0])
		else $error("queue empty after a sample beat");

	// A beat that completes the window produces an output beat.
	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		accept && emit |=> out_valid)
		else $error("expected result beat missing");

endmodule
